@@ hw/rtl/ndfc_pkg.sv @@
// Shared types, command codes and helpers for the nixie digit and fade controller.
// No dependencies; imported by every module of the block.

package ndfc_pkg;

    // Field widths
    localparam int MASK_W  = 10;
    localparam int DUTY_W  = 10;
    localparam int LEVEL_W = 8;
    localparam int DIGIT_W = 4;
    localparam int CMD_W   = 3;
    localparam int PERIOD_W = 8;
    localparam int ETICK_W = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OVERLAP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ON      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_OFF     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LEVEL   = 3'd6;

    // Effect modes
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCROLL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OVERLAP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 2'd3;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] FADE_STEP_RST   = 8'd2;
    localparam logic [PERIOD_W-1:0] SCROLL_STEP_RST = 8'd5;
    localparam logic [DUTY_W-1:0]   MIN_DUTY_RST    = 10'd36;
    localparam logic [DUTY_W-1:0]   MAX_DUTY_RST    = 10'd1023;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [DIGIT_W-1:0] digit;
        logic [LEVEL_W-1:0] level;
    } ndfc_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]  cathode_mask;
        logic [DUTY_W-1:0]  anode_duty;
        logic               anode_on;
        logic [LEVEL_W-1:0] brightness_now;
        logic               effect_busy;
    } ndfc_res_t;

    // Snapshot of the tube state after one command
    typedef struct packed {
        logic [MASK_W-1:0]  cathode_mask;
        logic [LEVEL_W-1:0] brightness;
        logic               enabled;
        logic               busy;
    } ndfc_stage_t;

    // Timing settings for the state engine
    typedef struct packed {
        logic [PERIOD_W-1:0] fade_step;
        logic [PERIOD_W-1:0] scroll_step;
    } ndfc_tick_cfg_t;

    // Duty settings for the output stage
    typedef struct packed {
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] span;
    } ndfc_duty_cfg_t;

    // One-hot cathode bit for a digit; codes above nine light nothing
    function automatic logic [MASK_W-1:0] digit_bit(input logic [DIGIT_W-1:0] d);
        logic [MASK_W-1:0] m;
        m = '0;
        if (d <= DIGIT_MAX)
        begin
            m[d] = 1'b1;
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/nixie_digit_and_fade_controller.sv @@
// Top level of the nixie digit and fade controller: configuration registers,
// state engine (ndfc_core) and duty/result stage (ndfc_duty). Depends on ndfc_pkg.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------------------
//  cmd     | cmd_valid, cmd_ready, cmd        | in        | ndfc_cmd_t
//  res     | res_valid, res_ready, res        | out       | ndfc_res_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, | in        | 2-bit index, 10-bit data
//          | cfg_data                         |           |
//
// One command per cycle while cmd_ready is high; each gives one result via both stages.
// The state update and the duty multiply/divide-by-255 each take one register stage.
// cfg_ready is always high; a write takes effect at the next edge.
// Reset clears tube state and loads the configuration defaults.
// A stalled result backs up through the two stages to cmd_ready.

module nixie_digit_and_fade_controller
    import ndfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  ndfc_cmd_t            cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output ndfc_res_t            res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUTY_W-1:0]    cfg_data
);

    logic [PERIOD_W-1:0] fade_step_reg;
    logic [PERIOD_W-1:0] scroll_step_reg;
    logic [DUTY_W-1:0]   min_duty_reg, min_duty_next;
    logic [DUTY_W-1:0]   max_duty_reg, max_duty_next;
    logic [DUTY_W-1:0]   span_reg, span_next;
    logic                cfg_write;

    ndfc_tick_cfg_t      tick_cfg;
    ndfc_duty_cfg_t      duty_cfg;
    logic                stage_valid;
    logic                stage_ready;
    ndfc_stage_t         stage;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Work out new duty limits and their span for a write
    always_comb
    begin
        min_duty_next = min_duty_reg;
        max_duty_next = max_duty_reg;
        case (cfg_index)
            CFG_MIN_DUTY:
            begin
                min_duty_next = cfg_data;
            end
            CFG_MAX_DUTY:
            begin
                max_duty_next = cfg_data;
            end
            default:
            begin
            end
        endcase
        span_next = (max_duty_next > min_duty_next) ? max_duty_next - min_duty_next : '0;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg   <= FADE_STEP_RST;
            scroll_step_reg <= SCROLL_STEP_RST;
            min_duty_reg    <= MIN_DUTY_RST;
            max_duty_reg    <= MAX_DUTY_RST;
            span_reg        <= MAX_DUTY_RST - MIN_DUTY_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_FADE_STEP)
            begin
                fade_step_reg <= cfg_data[PERIOD_W-1:0];
            end
            if (cfg_index == CFG_SCROLL_STEP)
            begin
                scroll_step_reg <= cfg_data[PERIOD_W-1:0];
            end
            min_duty_reg <= min_duty_next;
            max_duty_reg <= max_duty_next;
            span_reg     <= span_next;
        end
    end

    assign tick_cfg.fade_step   = fade_step_reg;
    assign tick_cfg.scroll_step = scroll_step_reg;
    assign duty_cfg.min_duty    = min_duty_reg;
    assign duty_cfg.span        = span_reg;

    ndfc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .tick_cfg    (tick_cfg),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage)
    );

    ndfc_duty u_duty (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage),
        .duty_cfg    (duty_cfg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

@@ hw/rtl/ndfc_core.sv @@
// Command decode and tube state engine: digit, effects, fade and on/off state.
// Depends on ndfc_pkg; feeds one state snapshot per transfer to ndfc_duty.

module ndfc_core
    import ndfc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ndfc_cmd_t      cmd,
    input  ndfc_tick_cfg_t tick_cfg,
    output logic           stage_valid,
    input  logic           stage_ready,
    output ndfc_stage_t    stage
);

    logic [MASK_W-1:0]   lit_reg, lit_next;
    logic [DIGIT_W-1:0]  shown_reg, shown_next;
    logic [DIGIT_W-1:0]  goal_reg, goal_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                passed_reg, passed_next;
    logic [ETICK_W-1:0]  eticks_reg, eticks_next;
    logic [LEVEL_W-1:0]  blev_reg, blev_next;
    logic [LEVEL_W-1:0]  bgoal_reg, bgoal_next;
    logic [PERIOD_W-1:0] fticks_reg, fticks_next;
    logic                en_reg, en_next;

    logic                stage_valid_reg;
    ndfc_stage_t         stage_reg;

    logic [PERIOD_W-1:0] scroll_period;
    logic [PERIOD_W-1:0] fade_period;
    logic [ETICK_W-1:0]  eticks_inc;
    logic [PERIOD_W-1:0] fticks_inc;
    logic [DIGIT_W-1:0]  step_digit;
    logic                digit_ok;
    logic                accept;

    assign cmd_ready   = !stage_valid_reg || stage_ready;
    assign accept      = cmd_valid && cmd_ready;
    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

    // Period of zero counts as one
    assign scroll_period = (tick_cfg.scroll_step == '0) ? 8'd1 : tick_cfg.scroll_step;
    assign fade_period   = (tick_cfg.fade_step == '0) ? 8'd1 : tick_cfg.fade_step;
    assign eticks_inc    = eticks_reg + 9'd1;
    assign fticks_inc    = fticks_reg + 8'd1;
    assign step_digit    = (shown_reg >= DIGIT_MAX) ? 4'd0 : shown_reg + 4'd1;
    assign digit_ok      = (cmd.digit <= DIGIT_MAX);

    // Decode the command and work out the next tube state
    always_comb
    begin
        lit_next    = lit_reg;
        shown_next  = shown_reg;
        goal_next   = goal_reg;
        mode_next   = mode_reg;
        passed_next = passed_reg;
        eticks_next = eticks_reg;
        blev_next   = blev_reg;
        bgoal_next  = bgoal_reg;
        fticks_next = fticks_reg;
        en_next     = en_reg;

        case (cmd.command)
            CMD_TICK:
            begin
                // Advance the running effect
                if (mode_reg == MODE_SCROLL)
                begin
                    eticks_next = eticks_inc;
                    if (eticks_inc >= {1'b0, scroll_period})
                    begin
                        eticks_next = '0;
                        lit_next    = (lit_reg & ~digit_bit(shown_reg))
                                    | (en_reg ? digit_bit(step_digit) : '0);
                        shown_next  = step_digit;
                        if (step_digit == goal_reg)
                        begin
                            if (passed_reg)
                            begin
                                mode_next = MODE_NORMAL;
                            end
                            else
                            begin
                                passed_next = 1'b1;
                            end
                        end
                    end
                end
                else if (mode_reg == MODE_OVERLAP)
                begin
                    eticks_next = eticks_inc;
                    if (eticks_inc >= {scroll_period, 1'b0})
                    begin
                        eticks_next = '0;
                        lit_next    = (lit_reg & ~digit_bit(shown_reg))
                                    | (en_reg ? digit_bit(goal_reg) : '0);
                        shown_next  = goal_reg;
                        mode_next   = MODE_NORMAL;
                    end
                end

                // Step brightness toward its target once per fade period
                fticks_next = fticks_inc;
                if (fticks_inc >= fade_period)
                begin
                    fticks_next = '0;
                    if (blev_reg < bgoal_reg)
                    begin
                        blev_next = blev_reg + 8'd1;
                    end
                    else if (blev_reg > bgoal_reg)
                    begin
                        blev_next = blev_reg - 8'd1;
                    end
                end
            end
            CMD_SET:
            begin
                if (digit_ok)
                begin
                    lit_next   = (lit_reg & ~digit_bit(shown_reg))
                               | (en_reg ? digit_bit(cmd.digit) : '0);
                    shown_next = cmd.digit;
                    goal_next  = cmd.digit;
                end
            end
            CMD_SCROLL:
            begin
                if (digit_ok)
                begin
                    eticks_next = '0;
                    mode_next   = MODE_SCROLL;
                    passed_next = 1'b0;
                    goal_next   = cmd.digit;
                end
            end
            CMD_OVERLAP:
            begin
                if (digit_ok)
                begin
                    eticks_next = '0;
                    mode_next   = MODE_OVERLAP;
                    goal_next   = cmd.digit;
                    lit_next    = lit_reg | (en_reg ? digit_bit(cmd.digit) : '0);
                end
            end
            CMD_ON:
            begin
                en_next   = 1'b1;
                lit_next  = lit_reg | digit_bit(shown_reg);
                mode_next = MODE_NORMAL;
            end
            CMD_OFF:
            begin
                lit_next = lit_reg & ~digit_bit(shown_reg);
                en_next  = 1'b0;
            end
            CMD_LEVEL:
            begin
                bgoal_next = cmd.level;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the tube state; update on each command transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg    <= '0;
            shown_reg  <= '0;
            goal_reg   <= '0;
            mode_reg   <= MODE_NORMAL;
            passed_reg <= 1'b0;
            eticks_reg <= '0;
            blev_reg   <= '0;
            bgoal_reg  <= '0;
            fticks_reg <= '0;
            en_reg     <= 1'b0;
        end
        else if (accept)
        begin
            lit_reg    <= lit_next;
            shown_reg  <= shown_next;
            goal_reg   <= goal_next;
            mode_reg   <= mode_next;
            passed_reg <= passed_next;
            eticks_reg <= eticks_next;
            blev_reg   <= blev_next;
            bgoal_reg  <= bgoal_next;
            fticks_reg <= fticks_next;
            en_reg     <= en_next;
        end
    end

    // Stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    // Capture the post-update snapshot for the duty stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.cathode_mask <= lit_next;
            stage_reg.brightness   <= blev_next;
            stage_reg.enabled      <= en_next;
            stage_reg.busy         <= (mode_next != MODE_NORMAL);
        end
    end

    // Shown digit is always a real digit
    assert property (@(posedge clk) disable iff (!rst_n)
        shown_reg <= DIGIT_MAX)
        else $error("shown digit out of range");

    // Brightness moves by at most one step per transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (blev_reg == $past(blev_reg))
                || (blev_reg == $past(blev_reg) + 8'd1)
                || (blev_reg == $past(blev_reg) - 8'd1))
        else $error("brightness jumped by more than one step");

    // Busy flag of the snapshot follows the effect mode
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (stage_reg.busy == (mode_reg != MODE_NORMAL)))
        else $error("busy flag disagrees with effect mode");

endmodule

@@ hw/rtl/ndfc_duty.sv @@
// Anode duty stage: maps brightness to PWM duty and holds the result register.
// Depends on ndfc_pkg; takes snapshots from ndfc_core.

module ndfc_duty
    import ndfc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           stage_valid,
    output logic           stage_ready,
    input  ndfc_stage_t    stage,
    input  ndfc_duty_cfg_t duty_cfg,
    output logic           res_valid,
    input  logic           res_ready,
    output ndfc_res_t      res
);

    localparam int PROD_W = LEVEL_W + DUTY_W;

    logic              res_valid_reg;
    ndfc_res_t         res_reg;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] est_sum;
    logic [DUTY_W-1:0] quot_est;
    logic [PROD_W-1:0] rem;
    logic [DUTY_W-1:0] quot;
    logic [DUTY_W-1:0] duty;
    logic              accept;

    assign stage_ready = !res_valid_reg || res_ready;
    assign accept      = stage_valid && stage_ready;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    // Scale brightness by the duty span
    assign prod = PROD_W'(stage.brightness) * PROD_W'(duty_cfg.span);

    // Divide by 255: series estimate, then one correction step
    assign est_sum  = prod + PROD_W'(prod[PROD_W-1:8]) + PROD_W'(prod[PROD_W-1:16]);
    assign quot_est = est_sum[PROD_W-1:8];
    assign rem      = prod + PROD_W'(quot_est) - {quot_est, 8'd0};
    assign quot     = (rem >= PROD_W'(255)) ? quot_est + 10'd1 : quot_est;
    assign duty     = stage.enabled ? duty_cfg.min_duty + quot : '0;

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            res_valid_reg <= stage_valid;
        end
    end

    // Load the result register on each stage transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg.cathode_mask   <= stage.cathode_mask;
            res_reg.anode_duty     <= duty;
            res_reg.anode_on       <= stage.enabled && (stage.brightness != '0);
            res_reg.brightness_now <= stage.brightness;
            res_reg.effect_busy    <= stage.busy;
        end
    end

    // Duty of a lit tube never falls below the minimum
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stage.enabled) |=> (res_reg.anode_duty >= duty_cfg.min_duty))
        else $error("duty below minimum");

    // Duty of a lit tube never exceeds minimum plus span
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stage.enabled) |=>
            ({1'b0, res_reg.anode_duty} <= {1'b0, duty_cfg.min_duty} + {1'b0, duty_cfg.span}))
        else $error("duty above maximum");

endmodule
